// ----- sv/pfc_pkg.sv -----
// Shared constants and letter maps for the period-five letter cipher.
package pfc_pkg;

  localparam int unsigned LETTERS = 26;
  localparam logic [7:0] CODE_A = 8'd65;
  localparam logic [7:0] CODE_Z = 8'd90;

  // Phase codes of the five-step key schedule.
  localparam logic [2:0] PH_SUB_0   = 3'd0;
  localparam logic [2:0] PH_SHIFT_1 = 3'd1;
  localparam logic [2:0] PH_SUB_2   = 3'd2;
  localparam logic [2:0] PH_SHIFT_3 = 3'd3;
  localparam logic [2:0] PH_SHIFT_4 = 3'd4;

  // Forward shift amounts, and their inverses modulo 26.
  localparam logic [4:0] SHIFT_FWD_A = 5'd5;
  localparam logic [4:0] SHIFT_INV_A = 5'd21;
  localparam logic [4:0] SHIFT_FWD_B = 5'd23;
  localparam logic [4:0] SHIFT_INV_B = 5'd3;

  typedef logic [4:0] letter_t;

  localparam letter_t FWD_SUB [LETTERS] = '{
    5'd3,  5'd10, 5'd21, 5'd16, 5'd5,  5'd8,  5'd1,  5'd9,  5'd22, 5'd15, 5'd4,  5'd18, 5'd2,
    5'd23, 5'd7,  5'd19, 5'd12, 5'd24, 5'd0,  5'd20, 5'd14, 5'd11, 5'd17, 5'd6,  5'd25, 5'd13
  };

  localparam letter_t INV_SUB [LETTERS] = '{
    5'd18, 5'd6,  5'd12, 5'd0,  5'd10, 5'd4,  5'd23, 5'd14, 5'd5,  5'd7,  5'd1,  5'd21, 5'd16,
    5'd25, 5'd20, 5'd9,  5'd3,  5'd22, 5'd11, 5'd15, 5'd19, 5'd2,  5'd8,  5'd13, 5'd17, 5'd24
  };

  // Substitution lookup; indexes past Z never reach the output.
  function automatic letter_t sub_lookup(input letter_t idx, input logic inverse);
    letter_t r;
    r = '0;
    if (32'(idx) < LETTERS) begin
      r = inverse ? INV_SUB[idx] : FWD_SUB[idx];
    end
    return r;
  endfunction

  // Add two letter indexes modulo 26; both are below 26.
  function automatic letter_t shift_mod(input letter_t idx, input letter_t amt);
    logic [5:0] sum;
    letter_t r;
    sum = {1'b0, idx} + {1'b0, amt};
    if (sum >= 6'(LETTERS)) begin
      sum = sum - 6'(LETTERS);
    end
    r = sum[4:0];
    return r;
  endfunction

endpackage

// ----- sv/pfc_xform.sv -----
// Per-byte letter transform selected by phase and mode.
module pfc_xform (
  input  logic [7:0] in_byte,
  input  logic [2:0] phase,
  input  logic       decrypt_mode,
  output logic [7:0] out_byte,
  output logic       not_letter
);

  logic            is_letter;
  pfc_pkg::letter_t idx;
  pfc_pkg::letter_t res;

  assign is_letter = (in_byte >= pfc_pkg::CODE_A) && (in_byte <= pfc_pkg::CODE_Z);
  assign idx       = 5'(in_byte - pfc_pkg::CODE_A);

  always_comb begin
    unique case (phase)
      pfc_pkg::PH_SUB_0,
      pfc_pkg::PH_SUB_2:   res = pfc_pkg::sub_lookup(idx, decrypt_mode);
      pfc_pkg::PH_SHIFT_1,
      pfc_pkg::PH_SHIFT_4: res = pfc_pkg::shift_mod(idx, decrypt_mode ?
                                   pfc_pkg::SHIFT_INV_A : pfc_pkg::SHIFT_FWD_A);
      pfc_pkg::PH_SHIFT_3: res = pfc_pkg::shift_mod(idx, decrypt_mode ?
                                   pfc_pkg::SHIFT_INV_B : pfc_pkg::SHIFT_FWD_B);
      default:             res = idx;
    endcase
  end

  assign out_byte   = is_letter ? (pfc_pkg::CODE_A + 8'(res)) : in_byte;
  assign not_letter = ~is_letter;

endmodule

// ----- sv/period_five_letter_cipher.sv -----
// Top level of the period-five letter cipher: input stage, phase counter, result stage.
//
//   channel  | direction | payload
//   s_axis   | in        | tdata = in_byte[7:0], tuser = start_of_message
//   m_axis   | out       | tdata = out_byte[7:0], tuser = not_letter
//   cfg      | in        | cfg_data = decrypt_mode
//
// One byte is accepted per cycle unless m_axis stalls; it is registered in the input stage, then the result stage.
// The phase is taken when the byte is accepted, so back-to-back bytes need no gap between them.
// Reset clears the phase, the mode and both valid flags; the cipher is ready at once.
// A stall on m_axis fills the input stage, then drops s_axis_tready.
// cfg_ready is always high; the mode should change only while the pipeline is empty.
module period_five_letter_cipher (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tuser,   // [0] start_of_message
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tuser,   // [0] not_letter
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

  logic       decrypt_mode;
  logic [2:0] phase;
  logic [2:0] item_phase;
  logic [2:0] phase_next;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic [2:0] s1_phase;
  logic       s1_move;
  logic       in_fire;

  logic [7:0] xf_byte;
  logic       xf_not_letter;

  assign cfg_ready     = 1'b1;
  assign s1_move       = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = ~s1_valid | s1_move;
  assign in_fire       = s_axis_tvalid & s_axis_tready;

  assign item_phase = s_axis_tuser ? pfc_pkg::PH_SUB_0 : phase;
  assign phase_next = (item_phase >= pfc_pkg::PH_SHIFT_4) ? pfc_pkg::PH_SUB_0
                                                           : item_phase + 3'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      decrypt_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      decrypt_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= pfc_pkg::PH_SUB_0;
      s1_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        phase <= phase_next;
      end
      if (s_axis_tready) begin
        s1_valid <= s_axis_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte  <= s_axis_tdata;
      s1_phase <= item_phase;
    end
  end

  pfc_xform u_xform (
    .in_byte      (s1_byte),
    .phase        (s1_phase),
    .decrypt_mode (decrypt_mode),
    .out_byte     (xf_byte),
    .not_letter   (xf_not_letter)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_move) begin
      m_axis_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_valid) begin
      m_axis_tdata <= xf_byte;
      m_axis_tuser <= xf_not_letter;
    end
  end

  // The phase counter never leaves its five codes.
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase <= pfc_pkg::PH_SHIFT_4)
    else $error("phase counter out of range");

  // A byte that opens a message runs at phase zero, so the next one sees phase one.
  a_start_phase: assert property (@(posedge clk) disable iff (rst)
    in_fire && s_axis_tuser |=> phase == pfc_pkg::PH_SHIFT_1)
    else $error("start of message did not restart the phase");

  // A held input stage keeps its item until the result register frees up.
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid && $stable(s1_byte) && $stable(s1_phase))
    else $error("input stage lost an item under stall");

  // A letter always comes out as a letter.
  a_letter_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |->
      (m_axis_tdata >= pfc_pkg::CODE_A) && (m_axis_tdata <= pfc_pkg::CODE_Z))
    else $error("letter result out of A to Z");

endmodule
